[sv/sali_pkg.sv]
// shared types and constants for the set-associative lru instruction cache
// no dependencies

package sali_pkg;

  localparam int ADDR_W      = 64;
  localparam int DATA_W      = 64;
  localparam int OFFSET_BITS = 1;
  localparam int PAGE_SHIFT  = 12;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_INV_ALL  = 2'd2,
    OP_INV_PAGE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_INV_ALL,
    ST_SWEEP_RD,
    ST_SWEEP_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic clear;
    logic lru_init;
    logic sweep_rd;
    logic sweep_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

[sv/sali_ram.sv]
// generic single write port ram with registered read
// no dependencies

module sali_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/sali_ctrl.sv]
// controller state machine for the instruction cache
// depends on sali_pkg

module sali_ctrl import sali_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  opcode,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_INIT: begin
        cmd.clear    = 1'b1;
        cmd.lru_init = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (opcode)
            OP_READ, OP_WRITE: state_next = ST_LOOKUP;
            OP_INV_ALL:        state_next = ST_INV_ALL;
            OP_INV_PAGE:       state_next = ST_SWEEP_RD;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_DONE;
      end
      ST_INV_ALL: begin
        cmd.clear = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SWEEP_RD: begin
        cmd.sweep_rd = 1'b1;
        state_next   = ST_SWEEP_CMP;
      end
      ST_SWEEP_CMP: begin
        cmd.sweep_cmp = 1'b1;
        state_next    = sts.sweep_last ? ST_DONE : ST_SWEEP_RD;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[sv/sali_dpath.sv]
// datapath: tag, payload, valid and lru rams, sweep counter, result register
// depends on sali_pkg and sali_ram

module sali_dpath import sali_pkg::*; #(
  parameter int SETS         = 64,
  parameter int WAYS         = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  op_t                     opcode,
  input  logic [ADDR_W-1:0]       address,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  cmd_t                    cmd,
  input  logic                    out_stall,
  output sts_t                    sts,
  output logic                    out_valid,
  output logic                    hit,
  output logic [DATA_W-1:0]       read_data
);

  localparam int IDX_W = $clog2(SETS);
  localparam int TAG_W = ADDR_W - OFFSET_BITS - IDX_W;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LRU_W = WAYS * WAY_W;

  logic [IDX_W-1:0]        raw_set;
  logic [IDX_W-1:0]        in_set;
  op_t                     op_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [IDX_W-1:0]        set_q;
  logic [TAG_W-1:0]        tag_q;
  logic [IDX_W-1:0]        cnt;

  logic [TAG_W-1:0]        tag_rd [WAYS];
  logic [PAYLOAD_BITS-1:0] pay_rd [WAYS];
  logic [WAYS-1:0]         valid_rd;
  logic [LRU_W-1:0]        lru_rd;
  logic [IDX_W-1:0]        rd_addr;
  logic                    rd_en;
  logic [WAYS-1:0]         wr_en;

  logic                       valid_we;
  logic [IDX_W-1:0]           valid_waddr;
  logic [WAYS-1:0]            valid_wdata;
  logic                       lru_we;
  logic [IDX_W-1:0]           lru_waddr;
  logic [LRU_W-1:0]           lru_wdata;
  logic [WAYS-1:0][WAY_W-1:0] lru_reset_row;

  logic [WAYS-1:0]            vrow;
  logic [WAYS-1:0][WAY_W-1:0] orow;
  logic [WAYS-1:0][WAY_W-1:0] orow_next;
  logic [WAYS-1:0]            way_hit;
  logic                       found;
  logic [WAY_W-1:0]           pos;
  logic [WAY_W-1:0]           pp;
  logic [WAY_W-1:0]           victim;
  logic [WAYS-1:0]            page_match;
  logic [ADDR_W-1:0]          rebuilt [WAYS];

  logic              res_hit;
  logic [DATA_W-1:0] res_data;

  // set index, wrapped once when the set count is not a power of two
  assign raw_set = address[OFFSET_BITS +: IDX_W];
  assign in_set  = ({1'b0, raw_set} >= (IDX_W + 1)'(SETS)) ? raw_set - IDX_W'(SETS) : raw_set;
  assign tag_q   = addr_q[ADDR_W-1:OFFSET_BITS+IDX_W];

  assign rd_addr = cmd.capture ? in_set : cnt;
  assign rd_en   = cmd.capture | cmd.sweep_rd;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    sali_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag_ram (
      .clk   (clk),
      .we    (wr_en[w]),
      .waddr (set_q),
      .wdata (tag_q),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (tag_rd[w])
    );
    sali_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SETS)) u_pay_ram (
      .clk   (clk),
      .we    (wr_en[w]),
      .waddr (set_q),
      .wdata (pay_q),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (pay_rd[w])
    );
  end

  sali_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid_ram (
    .clk   (clk),
    .we    (valid_we),
    .waddr (valid_waddr),
    .wdata (valid_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (valid_rd)
  );

  sali_ram #(.WIDTH(LRU_W), .DEPTH(SETS)) u_lru_ram (
    .clk   (clk),
    .we    (lru_we),
    .waddr (lru_waddr),
    .wdata (lru_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (lru_rd)
  );

  // lookup: search the lru order for a matching valid way
  always_comb begin
    vrow  = valid_rd;
    orow  = lru_rd;
    found = 1'b0;
    pos   = '0;
    for (int w = 0; w < WAYS; w++) begin
      way_hit[w] = vrow[w] && (tag_rd[w] == tag_q);
    end
    for (int p = 0; p < WAYS; p++) begin
      if (!found && way_hit[orow[p]]) begin
        found = 1'b1;
        pos   = WAY_W'(p);
      end
    end
    victim = orow[WAYS-1];
    pp     = found ? pos : WAY_W'(WAYS - 1);
    for (int p = 0; p < WAYS; p++) begin
      if (p == 0) begin
        orow_next[p] = orow[pp];
      end else if (WAY_W'(p) <= pp) begin
        orow_next[p] = orow[p-1];
      end else begin
        orow_next[p] = orow[p];
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      wr_en[w] = cmd.lookup && (op_q == OP_WRITE) && !found && (victim == WAY_W'(w));
    end
  end

  // page sweep compare on the set under the counter
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rebuilt[w]    = {tag_rd[w], cnt, {OFFSET_BITS{1'b0}}};
      page_match[w] = rebuilt[w][ADDR_W-1:PAGE_SHIFT] == addr_q[ADDR_W-1:PAGE_SHIFT];
    end
  end

  // valid and lru ram writes
  always_comb begin
    for (int p = 0; p < WAYS; p++) begin
      lru_reset_row[p] = WAY_W'(p);
    end
    valid_we    = cmd.clear | cmd.sweep_cmp | (|wr_en);
    valid_waddr = cmd.lookup ? set_q : cnt;
    if (cmd.clear) begin
      valid_wdata = '0;
    end else if (cmd.sweep_cmp) begin
      valid_wdata = valid_rd & ~page_match;
    end else begin
      valid_wdata = vrow | wr_en;
    end
    lru_we    = cmd.lru_init | (cmd.lookup && ((op_q == OP_WRITE) || found));
    lru_waddr = cmd.lookup ? set_q : cnt;
    lru_wdata = cmd.lru_init ? lru_reset_row : orow_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      addr_q <= address;
      pay_q  <= payload;
      set_q  <= in_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.sweep_cmp || cmd.clear) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_hit  <= 1'b0;
      res_data <= '0;
    end else if (cmd.lookup && (op_q == OP_READ) && found) begin
      res_hit  <= 1'b1;
      res_data <= DATA_W'(pay_rd[orow[pos]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit       <= res_hit;
      read_data <= res_data;
    end
  end

  assign sts.sweep_last = (cnt == IDX_W'(SETS - 1));
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

[sv/set_assoc_lru_instr_cache_core.sv]
// top level of the set-associative instruction cache with true lru per set
// depends on sali_pkg, sali_ctrl, sali_dpath, sali_ram
//
//   channel | handshake           | fields
//   input   | in_valid, in_stall   | opcode, address, payload
//   output  | out_valid, out_stall | hit, read_data
//
// read and write go through accept with ram read, then compare and lru update, then result load
// invalidate all clears one set per cycle; invalidate page reads and then compares
// each set in turn
// after reset a clearing pass zeroes valid bits and restores lru order
// a new item is taken while the previous result waits in the output register;
// a finished item waits in its last state while the output is stalled.

module set_assoc_lru_instr_cache_core import sali_pkg::*; #(
  parameter int SETS         = 64,
  parameter int WAYS         = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              opcode,
  input  logic [ADDR_W-1:0]       address,
  input  logic [DATA_W-1:0]       payload,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic [DATA_W-1:0]       read_data
);

  cmd_t cmd;
  sts_t sts;

  sali_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (op_t'(opcode)),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sali_dpath #(
    .SETS         (SETS),
    .WAYS         (WAYS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .opcode    (op_t'(opcode)),
    .address   (address),
    .payload   (payload[PAYLOAD_BITS-1:0]),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .hit       (hit),
    .read_data (read_data)
  );

endmodule
